// File: sv/ssrf_pkg.sv
// Package for the stereo sample ring FIFO.
// Holds the field widths, operation codes and the transfer payload structs.
// Depends on nothing; used by the top level stereo_sample_ring_fifo.
package ssrf_pkg;

    localparam int SAMPLE_W           = 16;
    localparam int LEVEL_W            = 10;
    localparam int COUNT_W            = 32;
    localparam int FUNC_W             = 2;
    localparam int RING_DEPTH_DEFAULT = 1024;

    // Operation codes carried in the func field.
    localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_FLUSH = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_NONE  = 2'd3;

    typedef struct packed {
        logic [FUNC_W-1:0]          func;
        logic signed [SAMPLE_W-1:0] left_in;
        logic signed [SAMPLE_W-1:0] right_in;
        logic                       burst_end;
    } in_item_t;

    typedef struct packed {
        logic                       accepted;
        logic signed [SAMPLE_W-1:0] left_out;
        logic signed [SAMPLE_W-1:0] right_out;
        logic [LEVEL_W-1:0]         fill_level;
        logic [LEVEL_W-1:0]         free_space;
        logic [COUNT_W-1:0]         overflow_count;
        logic [COUNT_W-1:0]         underrun_count;
    } out_item_t;

endpackage

// File: sv/ssrf_store.sv
// Sample pair store of the stereo sample ring FIFO.
// A simple dual-port memory: one write and one registered read per cycle.
// Depends on no package; widths come from the top level.
module ssrf_store #(
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = 10,
    parameter int DATA_W = 32
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port; the data register holds until the next read.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: sv/stereo_sample_ring_fifo.sv
// Top level of the stereo sample ring FIFO.
// Depends on ssrf_pkg and instantiates the pair store ssrf_store.
//
// The block takes one operation per clock while results are taken (write a
// pair, read a pair, flush, or nothing) and returns one result per operation,
// held in the input register and then in the result register. Sustained rate
// is one item per clock while results are taken, set by the single write and
// single read port of the pair store and by the result register; while a
// result waits to be taken, one further item is held in the input register.
// The ring keeps at most RING_DEPTH - 1 pairs. A failed write halts later
// writes of its burst and a failed read later reads, with no further count;
// the burst ends with the item whose burst_end bit is set. The store has no
// reset and needs no clearing pass, as only written entries are ever read.
module stereo_sample_ring_fifo #(
    parameter int RING_DEPTH = ssrf_pkg::RING_DEPTH_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  ssrf_pkg::in_item_t in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output ssrf_pkg::out_item_t out_data
);

    localparam int IDX_W  = $clog2(RING_DEPTH);
    localparam int EXT_W  = IDX_W + ssrf_pkg::LEVEL_W;
    localparam int PAIR_W = 2 * ssrf_pkg::SAMPLE_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(RING_DEPTH - 1);

    // Input register.
    logic               stage_valid_reg;
    ssrf_pkg::in_item_t stage_reg;

    // Ring state.
    logic [IDX_W-1:0]             head_reg, head_next;
    logic [IDX_W-1:0]             tail_reg, tail_next;
    logic [IDX_W-1:0]             fill_reg, fill_next;
    logic [ssrf_pkg::COUNT_W-1:0] overflow_reg, overflow_next;
    logic [ssrf_pkg::COUNT_W-1:0] underrun_reg, underrun_next;
    logic                         write_halted_reg, write_halted_next;
    logic                         read_halted_reg, read_halted_next;

    // Result register; samples come from the store's read register.
    logic                out_valid_reg;
    ssrf_pkg::out_item_t out_reg, out_next;
    logic                rd_ok_reg;

    logic              advance;
    logic              is_write, is_read, is_flush;
    logic              full, empty;
    logic              wr_ok, wr_fail, rd_ok, rd_fail;
    logic [EXT_W-1:0]  fill_ext, free_ext;
    logic [IDX_W-1:0]  free_w;
    logic [PAIR_W-1:0] rd_pair;

    // Handshake: the item moves on when the result register is free or emptying.
    assign advance  = stage_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !stage_valid_reg || advance;

    // Decode the held item against the current ring state.
    always_comb
    begin
        is_write = (stage_reg.func == ssrf_pkg::FUNC_WRITE);
        is_read  = (stage_reg.func == ssrf_pkg::FUNC_READ);
        is_flush = (stage_reg.func == ssrf_pkg::FUNC_FLUSH);
        full     = (fill_reg == LAST_IDX);
        empty    = (fill_reg == '0);
        wr_ok    = is_write && !write_halted_reg && !full;
        wr_fail  = is_write && !write_halted_reg && full;
        rd_ok    = is_read && !read_halted_reg && !empty;
        rd_fail  = is_read && !read_halted_reg && empty;
    end

    // Next state of the ring.
    always_comb
    begin
        head_next         = head_reg;
        tail_next         = tail_reg;
        fill_next         = fill_reg;
        overflow_next     = overflow_reg;
        underrun_next     = underrun_reg;
        write_halted_next = write_halted_reg;
        read_halted_next  = read_halted_reg;
        if (wr_ok)
        begin
            head_next = (head_reg == LAST_IDX) ? '0 : head_reg + 1'b1;
            fill_next = fill_reg + 1'b1;
        end
        if (rd_ok)
        begin
            tail_next = (tail_reg == LAST_IDX) ? '0 : tail_reg + 1'b1;
            fill_next = fill_reg - 1'b1;
        end
        if (is_flush)
        begin
            tail_next = head_reg;
            fill_next = '0;
        end
        if (wr_fail)
        begin
            overflow_next     = overflow_reg + 1'b1;
            write_halted_next = 1'b1;
        end
        if (rd_fail)
        begin
            underrun_next    = underrun_reg + 1'b1;
            read_halted_next = 1'b1;
        end
        if (stage_reg.burst_end)
        begin
            write_halted_next = 1'b0;
            read_halted_next  = 1'b0;
        end
    end

    // Result fields; levels are reported in their low ten bits.
    always_comb
    begin
        free_w                  = LAST_IDX - fill_next;
        fill_ext                = EXT_W'(fill_next);
        free_ext                = EXT_W'(free_w);
        out_next                = '0;
        out_next.accepted       = wr_ok || rd_ok || is_flush;
        out_next.fill_level     = fill_ext[ssrf_pkg::LEVEL_W-1:0];
        out_next.free_space     = free_ext[ssrf_pkg::LEVEL_W-1:0];
        out_next.overflow_count = overflow_next;
        out_next.underrun_count = underrun_next;
    end

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            stage_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            stage_reg <= in_data;
        end
    end

    // Ring state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg         <= '0;
            tail_reg         <= '0;
            fill_reg         <= '0;
            overflow_reg     <= '0;
            underrun_reg     <= '0;
            write_halted_reg <= 1'b0;
            read_halted_reg  <= 1'b0;
        end
        else if (advance)
        begin
            head_reg         <= head_next;
            tail_reg         <= tail_next;
            fill_reg         <= fill_next;
            overflow_reg     <= overflow_next;
            underrun_reg     <= underrun_next;
            write_halted_reg <= write_halted_next;
            read_halted_reg  <= read_halted_next;
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            rd_ok_reg     <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
            rd_ok_reg     <= rd_ok;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_reg <= out_next;
        end
    end

    // Pair store: left sample in the low half, right sample in the high half.
    ssrf_store #(
        .DEPTH  (RING_DEPTH),
        .ADDR_W (IDX_W),
        .DATA_W (PAIR_W)
    ) u_store (
        .clk     (clk),
        .wr_en   (advance && wr_ok),
        .wr_addr (head_reg),
        .wr_data ({stage_reg.right_in, stage_reg.left_in}),
        .rd_en   (advance && rd_ok),
        .rd_addr (tail_reg),
        .rd_data (rd_pair)
    );

    // Output payload; samples read as zero unless a read succeeded.
    always_comb
    begin
        out_data           = out_reg;
        out_data.left_out  = '0;
        out_data.right_out = '0;
        if (rd_ok_reg)
        begin
            out_data.left_out  = rd_pair[ssrf_pkg::SAMPLE_W-1:0];
            out_data.right_out = rd_pair[PAIR_W-1:ssrf_pkg::SAMPLE_W];
        end
    end

    assign out_valid = out_valid_reg;

    // The fill count agrees with the distance from tail to head.
    a_fill_matches_indices: assert property (@(posedge clk) disable iff (!rst_n)
        (head_reg >= tail_reg) ? (fill_reg == head_reg - tail_reg)
                               : (fill_reg == IDX_W'(RING_DEPTH - tail_reg + head_reg)))
        else $error("fill count disagrees with head and tail");

    // The ring never holds more than RING_DEPTH - 1 pairs.
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= LAST_IDX)
        else $error("fill count beyond ring capacity");

    // An item that ends a burst leaves both halt flags clear.
    a_burst_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        advance && stage_reg.burst_end |=> !write_halted_reg && !read_halted_reg)
        else $error("halt flag survived the end of a burst");

    // The failure counters hold while no item is processed.
    a_overflow_step: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(overflow_reg) && $stable(underrun_reg))
        else $error("failure counter moved without an item");

    // A pair is read only when the ring was not empty.
    a_read_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        advance && rd_ok |-> fill_reg != '0 && head_reg != tail_reg)
        else $error("read issued on an empty ring");

endmodule
